// ===== sv/mtd_pkg.sv =====
// mtd_pkg: shared types, encoding codes and the cp1251 upper-half table
// for the multi-charset text decoder.
// No dependencies; used by mtd_front, mtd_queue and the top level.
package mtd_pkg;

  // input encoding codes held in the mode register
  localparam logic [1:0] ENC_UTF16LE = 2'd0;
  localparam logic [1:0] ENC_UTF8    = 2'd1;
  localparam logic [1:0] ENC_CP1251  = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [31:0] code_point;
    logic        last;
  } res_t;

  // up to two results per byte; second is only used together with the first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  localparam logic [15:0] CP1251_MAP [128] = '{
    16'h0402,16'h0403,16'h201A,16'h0453,16'h201E,16'h2026,16'h2020,16'h2021,
    16'h20AC,16'h2030,16'h0409,16'h2039,16'h040A,16'h040C,16'h040B,16'h040F,
    16'h0452,16'h2018,16'h2019,16'h201C,16'h201D,16'h2022,16'h2013,16'h2014,
    16'h0020,16'h2122,16'h0459,16'h203A,16'h045A,16'h045C,16'h045B,16'h045F,
    16'h00A0,16'h040E,16'h045E,16'h0408,16'h00A4,16'h0490,16'h00A6,16'h00A7,
    16'h0401,16'h00A9,16'h0404,16'h00AB,16'h00AC,16'h00AD,16'h00AE,16'h0407,
    16'h00B0,16'h00B1,16'h0406,16'h0456,16'h0491,16'h00B5,16'h00B6,16'h00B7,
    16'h0451,16'h2116,16'h0454,16'h00BB,16'h0458,16'h0405,16'h0455,16'h0457,
    16'h0410,16'h0411,16'h0412,16'h0413,16'h0414,16'h0415,16'h0416,16'h0417,
    16'h0418,16'h0419,16'h041A,16'h041B,16'h041C,16'h041D,16'h041E,16'h041F,
    16'h0420,16'h0421,16'h0422,16'h0423,16'h0424,16'h0425,16'h0426,16'h0427,
    16'h0428,16'h0429,16'h042A,16'h042B,16'h042C,16'h042D,16'h042E,16'h042F,
    16'h0430,16'h0431,16'h0432,16'h0433,16'h0434,16'h0435,16'h0436,16'h0437,
    16'h0438,16'h0439,16'h043A,16'h043B,16'h043C,16'h043D,16'h043E,16'h043F,
    16'h0440,16'h0441,16'h0442,16'h0443,16'h0444,16'h0445,16'h0446,16'h0447,
    16'h0448,16'h0449,16'h044A,16'h044B,16'h044C,16'h044D,16'h044E,16'h044F
  };

  // utf-8 continuation byte count from a lead byte: run of ones below the top bit, at least one
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    casez (b[6:0])
      7'b1111111: len = 3'd7;
      7'b111111?: len = 3'd6;
      7'b11111??: len = 3'd5;
      7'b1111???: len = 3'd4;
      7'b111????: len = 3'd3;
      7'b11?????: len = 3'd2;
      default:    len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/mtd_front.sv =====
// mtd_front: accepts bytes, holds the mode register and decoding state,
// and classifies each byte into zero, one or two results for the queue.
// Depends on mtd_pkg.
module mtd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           space_ok,
  output mtd_pkg::push_t push
);

  logic [1:0]  encoding;
  logic [2:0]  bytes_remaining;
  logic [31:0] partial_value;
  logic [7:0]  held_low_byte;
  logic        low_byte_valid;

  logic [2:0]  bytes_remaining_next;
  logic [31:0] partial_value_next;
  logic [7:0]  held_low_byte_next;
  logic        low_byte_valid_next;

  logic        fire;
  logic [15:0] unit;
  logic [2:0]  len;
  logic [7:0]  lead_mask;
  logic [31:0] acc;
  logic [2:0]  rem_dec;

  assign in_ready = space_ok;
  assign fire     = in_valid && in_ready;

  assign unit      = {in_byte, held_low_byte};
  assign len       = mtd_pkg::lead_len(in_byte);
  assign lead_mask = 8'h1F >> (len - 3'd1);
  assign acc       = {partial_value[25:0], in_byte[5:0]};
  assign rem_dec   = bytes_remaining - 3'd1;

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    partial_value_next   = partial_value;
    held_low_byte_next   = held_low_byte;
    low_byte_valid_next  = low_byte_valid;
    push                 = '0;
    unique case (encoding)
      mtd_pkg::ENC_UTF16LE: begin
        if (!low_byte_valid) begin
          held_low_byte_next  = in_byte;
          low_byte_valid_next = 1'b1;
        end else begin
          held_low_byte_next  = 8'h00;
          low_byte_valid_next = 1'b0;
          push.v0             = 1'b1;
          push.r0.code_point  = {16'h0000, unit};
          push.r0.last        = (unit == 16'h0000);
        end
      end
      mtd_pkg::ENC_UTF8: begin
        if (in_byte == 8'h00) begin
          bytes_remaining_next = 3'd0;
          partial_value_next   = 32'h0;
          push.v0              = 1'b1;
          if (bytes_remaining != 3'd0) begin
            // cut-short sequence: partial value goes out ahead of the terminator
            push.v1            = 1'b1;
            push.r0.code_point = partial_value;
            push.r1.last       = 1'b1;
          end else begin
            push.r0.last = 1'b1;
          end
        end else if (bytes_remaining == 3'd0) begin
          if (!in_byte[7]) begin
            push.v0            = 1'b1;
            push.r0.code_point = {24'h0, in_byte};
          end else begin
            partial_value_next   = {24'h0, in_byte & lead_mask};
            bytes_remaining_next = len;
          end
        end else begin
          bytes_remaining_next = rem_dec;
          if (rem_dec == 3'd0) begin
            partial_value_next = 32'h0;
            push.v0            = 1'b1;
            push.r0.code_point = acc;
          end else begin
            partial_value_next = acc;
          end
        end
      end
      mtd_pkg::ENC_CP1251: begin
        push.v0 = 1'b1;
        if (in_byte == 8'h00) begin
          push.r0.last = 1'b1;
        end else if (!in_byte[7]) begin
          push.r0.code_point = {24'h0, in_byte};
        end else begin
          push.r0.code_point = {16'h0, mtd_pkg::CP1251_MAP[in_byte[6:0]]};
        end
      end
      default: ;
    endcase
    if (!fire) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding        <= mtd_pkg::ENC_UTF8;
      bytes_remaining <= 3'd0;
      partial_value   <= 32'h0;
      held_low_byte   <= 8'h00;
      low_byte_valid  <= 1'b0;
    end else if (cfg_we) begin
      encoding        <= cfg_wdata;
      bytes_remaining <= 3'd0;
      partial_value   <= 32'h0;
      held_low_byte   <= 8'h00;
      low_byte_valid  <= 1'b0;
    end else if (fire) begin
      bytes_remaining <= bytes_remaining_next;
      partial_value   <= partial_value_next;
      held_low_byte   <= held_low_byte_next;
      low_byte_valid  <= low_byte_valid_next;
    end
  end

endmodule

// ===== sv/mtd_queue.sv =====
// mtd_queue: result queue between decode front and output port; takes up
// to two results a cycle, hands out one per transaction from its head.
// Depends on mtd_pkg.
module mtd_queue #(
  parameter int DEPTH = mtd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mtd_pkg::push_t             push,
  input  logic                       pop,
  output mtd_pkg::res_t              head,
  output logic                       not_empty,
  output logic                       space_ok,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mtd_pkg::res_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr1;
  logic [PTR_W-1:0] wr_ptr2;
  logic [PTR_W-1:0] rd_ptr1;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] n_push;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    return q;
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr);
  assign wr_ptr2 = ptr_inc(wr_ptr1);
  assign rd_ptr1 = ptr_inc(rd_ptr);

  assign n_push     = CNT_W'(push.v0) + CNT_W'(push.v1);
  assign count_next = count + n_push - CNT_W'(pop);

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  // room for the worst case of two results from the next byte
  assign space_ok  = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.v1) begin
        wr_ptr <= wr_ptr2;
      end else if (push.v0) begin
        wr_ptr <= wr_ptr1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
      count <= count_next;
    end
  end

endmodule

// ===== sv/multi_charset_text_decoder.sv =====
// multi_charset_text_decoder: top level, byte stream in, code points out.
// Depends on mtd_pkg, mtd_front and mtd_queue.
//
// Input channel in_valid/in_ready/in_byte carries one raw byte per
// transaction. Output channel out_valid/out_ready carries code_point and
// end_of_string, one result per transaction. The mode register
// input_encoding is written with cfg_we (0 utf-16le, 1 utf-8, 2 cp1251,
// 3 drops all bytes); a write clears all decoding state.
// A byte is decoded in the cycle it is accepted and its results are written
// into the result queue before they reach the output. One byte per cycle is
// taken as long as the result queue has room for two results; a byte yields
// at most two results (a NUL ending a cut-short utf-8 sequence), so throughput
// is one byte per cycle whenever the receiver takes one result per cycle.
// When the receiver stalls, results collect in the queue (QUEUE_DEPTH
// entries) and in_ready drops once fewer than two entries are free.
// Synchronous reset empties the queue, selects utf-8 and clears all state.
module multi_charset_text_decoder #(
  parameter int QUEUE_DEPTH = mtd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  input_encoding,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] code_point,
  output logic        end_of_string
);

  mtd_pkg::push_t push;
  mtd_pkg::res_t  head;
  logic           space_ok;
  logic           pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign pop = out_valid && out_ready;

  mtd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (input_encoding),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .space_ok  (space_ok),
    .push      (push)
  );

  mtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .space_ok  (space_ok),
    .count     (q_count)
  );

  assign code_point    = head.code_point;
  assign end_of_string = head.last;

  // empty queue always has room for the next byte
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("queue empty but input stalled");

  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> (code_point == 32'h0))
    else $error("terminator with nonzero code point");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($bits(q_count))'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0 && push.r1.last)
    else $error("second result without first or not a terminator");

endmodule
